[sv/sri_pkg.sv]
// ----------------------------------------------------------------------------
// sri_pkg
// Shared constants and controller/datapath signal bundles for the sequence
// reorder insert unit.
// ----------------------------------------------------------------------------
package sri_pkg;

    localparam int unsigned SEQ_W = 32;
    localparam int unsigned TAG_W = 16;
    localparam int unsigned OUT_W = 7;

    localparam logic [SEQ_W-1:0] MSB_FLIP = 32'h8000_0000;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic shift;
        logic put;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic ins;
        logic shift_done;
    } t_stat;

endpackage

[sv/sri_ram.sv]
// ----------------------------------------------------------------------------
// sri_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module sri_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/sri_ctrl.sv]
// ----------------------------------------------------------------------------
// sri_ctrl
// Controller: sequences capture, scan, decision, shift, insert and result
// handoff for one item at a time.
// ----------------------------------------------------------------------------
module sri_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  sri_pkg::t_stat i_stat,
    output sri_pkg::t_cmd  o_cmd
);
    import sri_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_PUT = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (!i_stat.ins) begin
                    n_state = S_OUT;
                end else if (i_stat.shift_done) begin
                    n_state = S_PUT;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
endmodule

[sv/sri_dpath.sv]
// ----------------------------------------------------------------------------
// sri_dpath
// Datapath: entry store, list count, next-expected number, scan for
// duplicates and insert position, and the element-by-element shift.
// ----------------------------------------------------------------------------
module sri_dpath #(
    parameter int GROUP_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sri_pkg::t_cmd               i_cmd,
    output sri_pkg::t_stat              o_stat,
    input  logic                        i_start_group,
    input  logic [sri_pkg::SEQ_W-1:0]   i_seq_num,
    input  logic [sri_pkg::TAG_W-1:0]   i_packet_tag,
    output logic [1:0]                  o_status,
    output logic [sri_pkg::OUT_W-1:0]   o_position,
    output logic [sri_pkg::OUT_W-1:0]   o_entry_total
);
    import sri_pkg::*;

    localparam int AW = $clog2(GROUP_DEPTH);
    localparam int CW = $clog2(GROUP_DEPTH + 1);
    localparam int EW = SEQ_W + TAG_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(GROUP_DEPTH);

    logic [SEQ_W-1:0] r_seq;
    logic [TAG_W-1:0] r_tag;
    logic             r_start;
    logic [CW-1:0]    r_count;
    logic [SEQ_W-1:0] r_next;
    logic [CW-1:0]    r_idx;
    logic             r_chk;
    logic [CW-1:0]    r_chk_idx;
    logic             r_dup;
    logic [CW-1:0]    r_pos;
    logic [1:0]       r_status;
    logic [CW-1:0]    r_opos;
    logic             r_ins;
    logic [CW-1:0]    r_sh;
    logic             r_ph;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [EW-1:0]    ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [EW-1:0]    ram_rdata;
    logic [SEQ_W-1:0] rd_seq;
    logic [CW-1:0]    sh_m1;
    logic             eq_next;
    logic             fwd;
    logic [SEQ_W-1:0] d_up;
    logic [SEQ_W-1:0] d_dn;

    assign rd_seq = ram_rdata[EW-1:TAG_W];
    assign sh_m1 = r_sh - CW'(1);
    assign eq_next = (r_seq == r_next);
    assign d_up = r_seq - r_next;
    assign d_dn = r_next - r_seq;
    assign fwd = (r_seq > r_next) ? !d_up[SEQ_W-1] : d_dn[SEQ_W-1];

    always_comb begin
        ram_raddr = i_cmd.shift ? sh_m1[AW-1:0] : r_idx[AW-1:0];
        ram_we = 1'b0;
        ram_waddr = r_sh[AW-1:0];
        ram_wdata = ram_rdata;
        if (i_cmd.shift && r_ph) begin
            ram_we = 1'b1;
        end else if (i_cmd.put) begin
            ram_we = 1'b1;
            ram_waddr = r_opos[AW-1:0];
            ram_wdata = {r_seq, r_tag};
        end
    end

    sri_ram #(
        .WIDTH(EW),
        .DEPTH(GROUP_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_next <= '0;
            r_ins <= 1'b0;
            r_chk <= 1'b0;
            r_ph <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_chk <= 1'b0;
                if (i_start_group) begin
                    r_count <= '0;
                end
            end
            if (i_cmd.scan) begin
                r_chk <= (r_idx < r_count);
            end
            if (i_cmd.decide) begin
                r_ph <= 1'b0;
                r_ins <= 1'b0;
                if (!(!r_start && !eq_next && r_dup) && (r_count < FULL_CNT)) begin
                    r_ins <= 1'b1;
                    if (r_start || eq_next || fwd) begin
                        r_next <= r_seq + SEQ_W'(1);
                    end
                end
            end
            if (i_cmd.shift) begin
                r_ph <= !r_ph;
            end
            if (i_cmd.put) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_seq <= i_seq_num;
            r_tag <= i_packet_tag;
            r_start <= i_start_group;
            r_idx <= '0;
            r_dup <= 1'b0;
            r_pos <= '0;
        end
        if (i_cmd.scan) begin
            if (r_idx < r_count) begin
                r_chk_idx <= r_idx;
                r_idx <= r_idx + CW'(1);
            end
            if (r_chk) begin
                if (rd_seq == r_seq) begin
                    r_dup <= 1'b1;
                end
                // keep the last smaller entry in list order
                if ((rd_seq ^ MSB_FLIP) < (r_seq ^ MSB_FLIP)) begin
                    r_pos <= r_chk_idx + CW'(1);
                end
            end
        end
        if (i_cmd.decide) begin
            r_sh <= r_count;
            r_opos <= '0;
            if (!r_start && !eq_next && r_dup) begin
                r_status <= ST_DUPLICATE;
            end else if (r_count >= FULL_CNT) begin
                r_status <= ST_FULL;
            end else begin
                r_status <= ST_INSERTED;
                r_opos <= (r_start || eq_next || fwd) ? r_count : r_pos;
            end
        end
        // advance one element toward the back on the write phase of each read-then-write step
        if (i_cmd.shift && r_ph) begin
            r_sh <= sh_m1;
        end
    end

    assign o_stat.scan_done = (r_idx == r_count) && !r_chk;
    assign o_stat.ins = r_ins;
    assign o_stat.shift_done = (r_sh == r_opos);

    assign o_status = r_status;
    assign o_position = OUT_W'(r_opos);
    assign o_entry_total = OUT_W'(r_count);
endmodule

[sv/sequence_reorder_insert_unit.sv]
// ----------------------------------------------------------------------------
// sequence_reorder_insert_unit
// Ordered list of packet sequence numbers with tags; inserts, appends or
// rejects each arriving packet and reports where it went.
// ----------------------------------------------------------------------------
//  channel | handshake         | payload
//  --------+-------------------+-------------------------------------------
//  in      | i_valid / o_ready | i_start_group, i_seq_num, i_packet_tag
//  out     | o_valid / i_ready | o_status, o_position, o_entry_total
//
//  One item at a time. An inserted item is scanned against the list, one
//  store read per entry to check duplicates and find the slot, then the
//  entries from its slot on are moved back one place each (read then write
//  on the single store port pair) before it is written. A rejected item
//  is scanned the same way but skips the move and the write.
//  Reset clears the count and next-expected number; the store needs none.
//  A stalled result holds the unit; o_ready returns once it is taken.
// ----------------------------------------------------------------------------
module sequence_reorder_insert_unit #(
    parameter int GROUP_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_start_group,
    input  logic [sri_pkg::SEQ_W-1:0]   i_seq_num,
    input  logic [sri_pkg::TAG_W-1:0]   i_packet_tag,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_status,
    output logic [sri_pkg::OUT_W-1:0]   o_position,
    output logic [sri_pkg::OUT_W-1:0]   o_entry_total
);
    import sri_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sri_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .i_stat (stat),
        .o_cmd  (cmd)
    );

    sri_dpath #(
        .GROUP_DEPTH(GROUP_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_start_group(i_start_group),
        .i_seq_num    (i_seq_num),
        .i_packet_tag (i_packet_tag),
        .o_status     (o_status),
        .o_position   (o_position),
        .o_entry_total(o_entry_total)
    );
endmodule

[tb/sv/sequence_reorder_insert_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequence_reorder_insert_unit_test
// Drives packet items into the reorder insert unit under several idle and
// stall patterns and checks every result against a list model kept here.
// ----------------------------------------------------------------------------
module sequence_reorder_insert_unit_test;
    import sri_pkg::*;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [1:0]       status;
        logic [OUT_W-1:0] position;
        logic [OUT_W-1:0] entry_total;
    } t_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic             i_start_group;
    logic [SEQ_W-1:0] i_seq_num;
    logic [TAG_W-1:0] i_packet_tag;
    logic             o_valid;
    logic             i_ready;
    logic [1:0]       o_status;
    logic [OUT_W-1:0] o_position;
    logic [OUT_W-1:0] o_entry_total;

    sequence_reorder_insert_unit #(.GROUP_DEPTH(DEPTH)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_start_group(i_start_group), .i_seq_num(i_seq_num),
        .i_packet_tag(i_packet_tag),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_position(o_position),
        .o_entry_total(o_entry_total)
    );

    // list model
    logic [SEQ_W-1:0] list_seq[$];
    logic [TAG_W-1:0] list_tag[$];
    logic [SEQ_W-1:0] next_seq;
    t_result          pending_q[$];

    int  error_count;
    int  items_sent;
    int  results_seen;
    int  full_seen;
    int  dup_seen;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_len;
    int  cycle_count;
    int  group_left;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("sequence_reorder_insert_unit verification failed");
            $finish;
        end
    end

    // receiver ready, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            hold_len = hold_len - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want,
                 results_seen);
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", int'(o_status), -1);
            end else begin
                exp_r = pending_q.pop_front();
                if (o_status != exp_r.status)
                    report_mismatch("status", int'(o_status), int'(exp_r.status));
                if (o_position != exp_r.position)
                    report_mismatch("position", int'(o_position), int'(exp_r.position));
                if (o_entry_total != exp_r.entry_total)
                    report_mismatch("entry_total", int'(o_entry_total),
                                    int'(exp_r.entry_total));
            end
            results_seen++;
        end
    end

    function automatic bit is_listed(input logic [SEQ_W-1:0] seq);
        foreach (list_seq[k])
            if (list_seq[k] == seq) return 1'b1;
        return 1'b0;
    endfunction

    task automatic predict_insert(input logic start, input logic [SEQ_W-1:0] seq,
                                  input logic [TAG_W-1:0] tag);
        t_result r;
        logic [SEQ_W-1:0] diff;
        bit ahead;
        int slot;
        r.status = ST_INSERTED;
        r.position = '0;
        if (start) begin
            list_seq.delete();
            list_tag.delete();
            list_seq.push_back(seq);
            list_tag.push_back(tag);
            next_seq = seq + 1;
        end else if (seq != next_seq && is_listed(seq)) begin
            r.status = ST_DUPLICATE;
            dup_seen++;
        end else if (list_seq.size() >= DEPTH) begin
            r.status = ST_FULL;
            full_seen++;
        end else begin
            if (seq == next_seq) begin
                ahead = 1'b1;
            end else if (seq > next_seq) begin
                diff = seq - next_seq;
                ahead = (diff & MSB_FLIP) == 0;
            end else begin
                diff = next_seq - seq;
                ahead = (diff & MSB_FLIP) != 0;
            end
            if (ahead) begin
                slot = list_seq.size();
                next_seq = seq + 1;
            end else begin
                // place after the last entry, from the back, that is smaller
                slot = 0;
                for (int k = list_seq.size() - 1; k >= 0; k--) begin
                    if ((list_seq[k] ^ MSB_FLIP) < (seq ^ MSB_FLIP)) begin
                        slot = k + 1;
                        break;
                    end
                end
            end
            list_seq.insert(slot, seq);
            list_tag.insert(slot, tag);
            r.position = slot[OUT_W-1:0];
        end
        r.entry_total = OUT_W'(list_seq.size());
        pending_q.push_back(r);
    endtask

    // offer one item, hold it until taken, then maybe idle
    task automatic send_item(input logic start, input logic [SEQ_W-1:0] seq,
                             input logic [TAG_W-1:0] tag);
        i_valid <= 1'b1;
        i_start_group <= start;
        i_seq_num <= seq;
        i_packet_tag <= tag;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_insert(start, seq, tag);
        items_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed;
        send_item(1'b0, 32'd0, 16'h0000);           // in order from reset
        send_item(1'b0, 32'd5, 16'hFFFF);           // forward jump
        send_item(1'b0, 32'd3, 16'h1234);           // old packet
        send_item(1'b0, 32'd3, 16'h4321);           // duplicate
        send_item(1'b0, 32'h8000_0006, 16'h0001);   // half-range ahead: old, front
        send_item(1'b1, 32'hFFFF_FFFF, 16'hA5A5);   // start at top
        send_item(1'b0, 32'd0, 16'h5A5A);           // wrap in order
        send_item(1'b0, 32'h8000_0000, 16'h0F0F);   // jump just under half
        send_item(1'b0, 32'hFFFF_FFFE, 16'hF0F0);   // jump ahead, just under half range
        send_item(1'b0, 32'h7FFF_FFFF, 16'h00FF);
        // in-order number that is already stored
        send_item(1'b1, 32'd100, 16'h1111);
        send_item(1'b0, 32'd50, 16'h2222);
        send_item(1'b0, 32'h8000_0063, 16'h3333);
        send_item(1'b0, 32'hFFFF_FFF4, 16'h4444);
        send_item(1'b0, 32'd49, 16'h5555);
        send_item(1'b0, 32'd50, 16'h6666);
        drain();
    endtask

    task automatic test_full_store;
        logic [SEQ_W-1:0] base;
        base = $urandom;
        send_item(1'b1, base, TAG_W'($urandom));
        for (int k = 1; k < DEPTH + 4; k++)
            send_item(1'b0, base + k, TAG_W'($urandom));
        send_item(1'b0, base + 2, TAG_W'($urandom));        // duplicate while full
        send_item(1'b0, base - 7, TAG_W'($urandom));        // old while full
        drain();
    endtask

    task automatic next_random(output logic start, output logic [SEQ_W-1:0] seq);
        int pick;
        start = 1'b0;
        pick = $urandom_range(99);
        if (group_left <= 0 || pick >= 97) begin
            start = 1'b1;
            case ($urandom_range(3))
                0: seq = 32'hFFFF_FFFF - $urandom_range(20);
                1: seq = 32'h7FFF_FFFF - $urandom_range(20);
                default: seq = $urandom;
            endcase
            group_left = ($urandom_range(11) == 0) ? 75 : $urandom_range(2, 16);
        end else if (pick < 55) begin
            seq = next_seq;
        end else if (pick < 70) begin
            seq = next_seq - $urandom_range(2, 40);
        end else if (pick < 82 && list_seq.size() > 0) begin
            seq = list_seq[$urandom_range(list_seq.size() - 1)];
        end else if (pick < 90) begin
            seq = next_seq + $urandom_range(1, 50);
        end else if (pick < 93) begin
            seq = next_seq + (MSB_FLIP - $urandom_range(0, 2));
        end else begin
            seq = $urandom;
        end
        group_left--;
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        logic start;
        logic [SEQ_W-1:0] seq;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < count; k++) begin
            next_random(start, seq);
            send_item(start, seq, TAG_W'($urandom));
        end
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure;
        logic start;
        logic [SEQ_W-1:0] seq;
        hold_len = 3000;
        for (int k = 0; k < 30; k++) begin
            next_random(start, seq);
            send_item(start, seq, TAG_W'($urandom));
        end
        drain();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_start_group <= 1'b0;
        i_seq_num <= '0;
        i_packet_tag <= '0;
        next_seq = '0;
        error_count = 0;
        items_sent = 0;
        results_seen = 0;
        full_seen = 0;
        dup_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_len = 0;
        cycle_count = 0;
        group_left = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_store();
        run_random(450, 0, 0);
        run_random(450, 81, 0);
        run_random(450, 0, 81);
        run_random(450, 26, 26);
        test_backpressure();

        $display("sent %0d items, checked %0d results (%0d duplicates, %0d full)",
                 items_sent, results_seen, dup_seen, full_seen);
        $display("covered wrap, half-range jumps, old inserts, full store and long stall");
        if (error_count == 0) begin
            $display("sequence_reorder_insert_unit verification clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("sequence_reorder_insert_unit verification failed");
        end
        $finish;
    end

endmodule

[sequence_reorder_insert_unit.f]
sv/sri_pkg.sv
sv/sri_ram.sv
sv/sri_ctrl.sv
sv/sri_dpath.sv
sv/sequence_reorder_insert_unit.sv
tb/sv/sequence_reorder_insert_unit_test.sv
